// File: sv/pmtf_pkg.sv
// ----------------------------------------------------------------------------
// pmtf_pkg
// Shared widths, phase constants and sticky flag bit positions for the
// phased multirate tick flag block.
// ----------------------------------------------------------------------------
package pmtf_pkg;

	// payload widths
	localparam int unsigned MS_W   = 32;
	localparam int unsigned MASK_W = 8;

	// last phase value of each period (wraps to zero after it)
	localparam logic [3:0] PH10_LAST  = 4'd9;
	localparam logic [4:0] PH20_LAST  = 5'd19;
	localparam logic [6:0] PH100_LAST = 7'd99;
	localparam logic [7:0] PH200_LAST = 8'd199;
	localparam logic [8:0] PH300_LAST = 9'd299;
	localparam logic [8:0] PH500_LAST = 9'd499;

	// phase value at which each flag fires
	localparam logic [3:0] PH10_HIT  = 4'd0;
	localparam logic [4:0] PH20_HIT  = 5'd15;
	localparam logic [6:0] PH100_HIT = 7'd0;
	localparam logic [7:0] PH200_HIT = 8'd0;
	localparam logic [8:0] PH300_HIT = 9'd250;
	localparam logic [8:0] PH500_HIT = 9'd300;

	// sticky flag bit positions, same layout as clear_mask
	localparam int unsigned FLG_10      = 0;
	localparam int unsigned FLG_20      = 1;
	localparam int unsigned FLG_100     = 2;
	localparam int unsigned FLG_200     = 3;
	localparam int unsigned FLG_300     = 4;
	localparam int unsigned FLG_500     = 5;
	localparam int unsigned FLG_EDGE    = 6;
	localparam int unsigned FLG_STARTED = 7;

endpackage

// File: sv/pmtf_if.sv
// ----------------------------------------------------------------------------
// pmtf_if
// Valid/ready channels of the tick flag block: tick input and flag result.
// ----------------------------------------------------------------------------

// tick input channel
interface pmtf_tick_if
	import pmtf_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              wd_pin;
	logic [MASK_W-1:0] clear_mask;

	modport source (output valid, wd_pin, clear_mask, input ready);
	modport sink   (input valid, wd_pin, clear_mask, output ready);
endinterface

// flag result channel
interface pmtf_flags_if
	import pmtf_pkg::*;
();
	logic            valid;
	logic            ready;
	logic            flag_10ms;
	logic            flag_20ms;
	logic            flag_100ms;
	logic            flag_200ms;
	logic            flag_300ms;
	logic            flag_500ms;
	logic            keepalive_level;
	logic            wd_started;
	logic            wd_rise_event;
	logic [MS_W-1:0] ms_count;

	modport source (
		output valid, flag_10ms, flag_20ms, flag_100ms, flag_200ms, flag_300ms,
		       flag_500ms, keepalive_level, wd_started, wd_rise_event, ms_count,
		input  ready
	);
	modport sink (
		input  valid, flag_10ms, flag_20ms, flag_100ms, flag_200ms, flag_300ms,
		       flag_500ms, keepalive_level, wd_started, wd_rise_event, ms_count,
		output ready
	);
endinterface

// File: sv/phased_multirate_tick_flags.sv
// ----------------------------------------------------------------------------
// phased_multirate_tick_flags
// Millisecond tick counter with six phased multirate sticky flags, a
// keepalive toggle and watchdog pin start/edge capture.
// ----------------------------------------------------------------------------
// Usage
//   ticks  : one transfer per 1 ms tick, carrying the sampled watchdog pin
//            and a clear mask for the sticky flags (clear before set).
//   flags  : one result per tick, showing the flags, keepalive level and
//            millisecond count after that tick.
// Path: a tick goes into the input register, then into the state register
//   that also drives the result.
// Throughput: one tick per clock cycle while the receiver takes each result;
//   the update is a handful of narrow increments and compares between the input register and the state.
// Reset: count, phases, sticky flags, keepalive and pin history go to zero;
//   no result is pending.
// Stall: while the receiver holds ready low the result and all state hold;
//   one further tick is taken into the input register and waits there,
//   then ticks.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module phased_multirate_tick_flags
	import pmtf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	pmtf_tick_if.sink    ticks,
	pmtf_flags_if.source flags
);

	// input register
	logic              s1_valid_q;
	logic              wd_pin_s1;
	logic [MASK_W-1:0] clear_mask_s1;

	// state, which is also the result register
	logic              res_valid_q;
	logic [MS_W-1:0]   ms_q;
	logic [3:0]        ph10_q;
	logic [4:0]        ph20_q;
	logic [6:0]        ph100_q;
	logic [7:0]        ph200_q;
	logic [8:0]        ph300_q;
	logic [8:0]        ph500_q;
	logic [MASK_W-1:0] sticky_q;
	logic              keep_q;
	logic              pin_prev_q;

	// next state
	logic [3:0]        ph10_nxt;
	logic [4:0]        ph20_nxt;
	logic [6:0]        ph100_nxt;
	logic [7:0]        ph200_nxt;
	logic [8:0]        ph300_nxt;
	logic [8:0]        ph500_nxt;
	logic [MASK_W-1:0] sticky_nxt;
	logic              hit300;
	logic              out_free;
	logic              s1_adv;

	// handshake
	assign out_free    = !res_valid_q || flags.ready;
	assign s1_adv      = s1_valid_q && out_free;
	assign ticks.ready = !s1_valid_q || out_free;

	// phase advance, wrapping at the end of each period
	assign ph10_nxt  = (ph10_q  >= PH10_LAST)  ? '0 : ph10_q  + 4'd1;
	assign ph20_nxt  = (ph20_q  >= PH20_LAST)  ? '0 : ph20_q  + 5'd1;
	assign ph100_nxt = (ph100_q >= PH100_LAST) ? '0 : ph100_q + 7'd1;
	assign ph200_nxt = (ph200_q >= PH200_LAST) ? '0 : ph200_q + 8'd1;
	assign ph300_nxt = (ph300_q >= PH300_LAST) ? '0 : ph300_q + 9'd1;
	assign ph500_nxt = (ph500_q >= PH500_LAST) ? '0 : ph500_q + 9'd1;
	assign hit300    = (ph300_nxt == PH300_HIT);

	// sticky flags: clear first, then this tick's sets
	always_comb begin
		sticky_nxt = sticky_q & ~clear_mask_s1;
		if (ph10_nxt == PH10_HIT)   sticky_nxt[FLG_10]  = 1'b1;
		if (ph20_nxt == PH20_HIT)   sticky_nxt[FLG_20]  = 1'b1;
		if (ph100_nxt == PH100_HIT) sticky_nxt[FLG_100] = 1'b1;
		if (ph200_nxt == PH200_HIT) sticky_nxt[FLG_200] = 1'b1;
		if (hit300)                 sticky_nxt[FLG_300] = 1'b1;
		if (ph500_nxt == PH500_HIT) sticky_nxt[FLG_500] = 1'b1;
		if (wd_pin_s1) begin
			sticky_nxt[FLG_STARTED] = 1'b1;
			if (!pin_prev_q) sticky_nxt[FLG_EDGE] = 1'b1;
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (ticks.ready) begin
			s1_valid_q <= ticks.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (ticks.valid && ticks.ready) begin
			wd_pin_s1     <= ticks.wd_pin;
			clear_mask_s1 <= ticks.clear_mask;
		end
	end

	// tick state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			ms_q        <= '0;
			ph10_q      <= '0;
			ph20_q      <= '0;
			ph100_q     <= '0;
			ph200_q     <= '0;
			ph300_q     <= '0;
			ph500_q     <= '0;
			sticky_q    <= '0;
			keep_q      <= 1'b0;
			pin_prev_q  <= 1'b0;
		end else begin
			if (out_free) res_valid_q <= s1_valid_q;
			if (s1_adv) begin
				ms_q       <= ms_q + 32'd1;
				ph10_q     <= ph10_nxt;
				ph20_q     <= ph20_nxt;
				ph100_q    <= ph100_nxt;
				ph200_q    <= ph200_nxt;
				ph300_q    <= ph300_nxt;
				ph500_q    <= ph500_nxt;
				sticky_q   <= sticky_nxt;
				keep_q     <= keep_q ^ hit300;
				pin_prev_q <= wd_pin_s1;
			end
		end
	end

	// result fields straight from the state
	assign flags.valid           = res_valid_q;
	assign flags.flag_10ms       = sticky_q[FLG_10];
	assign flags.flag_20ms       = sticky_q[FLG_20];
	assign flags.flag_100ms      = sticky_q[FLG_100];
	assign flags.flag_200ms      = sticky_q[FLG_200];
	assign flags.flag_300ms      = sticky_q[FLG_300];
	assign flags.flag_500ms      = sticky_q[FLG_500];
	assign flags.keepalive_level = keep_q;
	assign flags.wd_started      = sticky_q[FLG_STARTED];
	assign flags.wd_rise_event   = sticky_q[FLG_EDGE];
	assign flags.ms_count        = ms_q;

endmodule

// File: sv/pmtf_checker.sv
// ----------------------------------------------------------------------------
// pmtf_checker
// Port-level checks on the flag result channel of the tick flag block.
// ----------------------------------------------------------------------------
module pmtf_checker
	import pmtf_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_ready,
	input logic            flag_300ms,
	input logic            keepalive_level,
	input logic [MS_W-1:0] ms_count
);

	logic            seen_q;
	logic [MS_W-1:0] last_ms_q;
	logic            last_keep_q;
	logic            out_xfer;

	assign out_xfer = out_valid && out_ready;

	// history of the last result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			last_ms_q   <= '0;
			last_keep_q <= 1'b0;
		end else if (out_xfer) begin
			seen_q      <= 1'b1;
			last_ms_q   <= ms_count;
			last_keep_q <= keepalive_level;
		end
	end

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ms_count))
		else $error("result changed while stalled");

	// first result after reset counts one tick
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && !seen_q |-> ms_count == 32'd1)
		else $error("first result count is not one");

	// results count up by exactly one tick
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && seen_q |-> ms_count == last_ms_q + 32'd1)
		else $error("result count skipped or repeated");

	// keepalive only toggles on a 300 ms event
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && seen_q && (keepalive_level != last_keep_q) |-> flag_300ms)
		else $error("keepalive toggled without 300 ms event");

endmodule

bind phased_multirate_tick_flags pmtf_checker u_pmtf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (flags.valid),
	.out_ready       (flags.ready),
	.flag_300ms      (flags.flag_300ms),
	.keepalive_level (flags.keepalive_level),
	.ms_count        (flags.ms_count)
);
